### rtl/fit_policy_block_allocator_top_macros.svh
// Assertion macros for the fit-policy block allocator.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FPBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fpba_pkg.sv
// Shared types and constants for the fit-policy block allocator.
// No dependencies; imported by the front, back and top modules.
`timescale 1ns / 1ps

package fpba_pkg;

  localparam int POLICY_W = 2;
  localparam int BLK_W    = 4;
  localparam int SIZE_W   = 16;

  // Depth of the command queue between front and back.
  localparam int CMDQ_DEPTH = 2;

  localparam logic [POLICY_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] FIT_WORST = 2'd2;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_ALLOC = 1'b1;

  typedef struct packed {
    logic              is_alloc;
    logic [BLK_W-1:0]  blk;
    logic [SIZE_W-1:0] size;
  } cmd_t;

  typedef struct packed {
    logic              granted;
    logic [BLK_W-1:0]  chosen_block;
    logic [SIZE_W-1:0] room_left;
  } res_t;

endpackage

### rtl/fit_policy_block_allocator_top.sv
// Fit-policy block allocator. A load request sets one block's capacity; an
// allocate request scans every block one per cycle through the capacity
// memory's single read port and then writes back. A two-entry command
// queue lets new requests be pushed while a scan runs, and a result
// register holds the answer until it is popped. Blocks start empty.
// Top level; depends on fpba_pkg, fpba_front, fpba_back and the macro header.
`timescale 1ns / 1ps
`include "fit_policy_block_allocator_top_macros.svh"

module fit_policy_block_allocator_top
  import fpba_pkg::*;
#(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [POLICY_W-1:0] cfg_data_i,
  input  logic                push_i,
  output logic                full_o,
  input  logic                mode_i,
  input  logic [BLK_W-1:0]    block_index_i,
  input  logic [SIZE_W-1:0]   size_value_i,
  output logic                empty_o,
  input  logic                pop_i,
  output logic                granted_o,
  output logic [BLK_W-1:0]    chosen_block_o,
  output logic [SIZE_W-1:0]   room_left_o
);

  logic [POLICY_W-1:0] fit_policy_q;
  logic                cmd_valid;
  cmd_t                cmd;
  logic                cmd_pop;
  logic                res_valid;
  res_t                res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_policy_q <= FIT_FIRST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fit_policy_q <= cfg_data_i;
    end
  end

  fpba_front #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .mode_i        (mode_i),
    .block_index_i (block_index_i),
    .size_value_i  (size_value_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  fpba_back #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fit_policy_i (fit_policy_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_pop_i    (pop_i)
  );

  assign empty_o        = !res_valid;
  assign granted_o      = res.granted;
  assign chosen_block_o = res.chosen_block;
  assign room_left_o    = res.room_left;

  `FPBA_ASSERT_NOW(a_nogrant_zero, !empty_o && !granted_o, (chosen_block_o == '0) && (room_left_o == '0), "denied request carries nonzero fields")
  `FPBA_ASSERT_NOW(a_full_has_cmd, full_o, cmd_valid, "command queue full but reports no command")
  `FPBA_ASSERT_NXT(a_cfg_write, cfg_valid_i && cfg_ready_o, fit_policy_q == $past(cfg_data_i), "policy register missed a write")

endmodule

### rtl/fpba_front.sv
// Front end: accepts input requests, drops out-of-range loads and queues
// the rest for the back end. Depends on fpba_pkg.
`timescale 1ns / 1ps

module fpba_front
  import fpba_pkg::*;
#(
  parameter int NUM_BLOCKS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic              mode_i,
  input  logic [BLK_W-1:0]  block_index_i,
  input  logic [SIZE_W-1:0] size_value_i,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_pop_i
);

  localparam int PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             q_mem [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept;
  logic             useful;
  logic             enq;
  logic             deq;
  cmd_t             cmd_in;

  assign full_o      = (cnt_q == CNT_W'(CMDQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];

  assign accept = push_i && !full_o;
  // A load to a block that does not exist has no effect and is dropped here.
  assign useful = (mode_i == MODE_ALLOC) || (int'(block_index_i) < NUM_BLOCKS);
  assign enq    = accept && useful;
  assign deq    = cmd_pop_i && cmd_valid_o;

  assign cmd_in.is_alloc = (mode_i == MODE_ALLOC);
  assign cmd_in.blk      = block_index_i;
  assign cmd_in.size     = size_value_i;

  always_comb begin
    wr_ptr_d = enq ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = deq ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    unique case ({enq, deq})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

### rtl/fpba_back.sv
// Back end: holds the capacity table, runs the fit scan one block per cycle,
// writes back the chosen block and keeps the result register. Uses fpba_pkg.
`timescale 1ns / 1ps

module fpba_back
  import fpba_pkg::*;
#(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [POLICY_W-1:0] fit_policy_i,
  input  logic                cmd_valid_i,
  input  cmd_t                cmd_i,
  output logic                cmd_pop_o,
  output logic                res_valid_o,
  output res_t                res_o,
  input  logic                res_pop_i
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WB
  } state_e;

  state_e                 state_q;
  logic [SIZE_BITS-1:0]   cap_mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0]  vld_q;
  logic [IDX_W-1:0]       rd_idx_q;
  logic [SIZE_BITS-1:0]   rd_data_q;
  logic                   rd_hit_q;
  logic [IDX_W-1:0]       cmp_idx_q;
  logic                   cmp_vld_q;
  logic [SIZE_BITS-1:0]   size_q;
  logic [SIZE_BITS-1:0]   best_q;
  logic [IDX_W-1:0]       pick_q;
  logic                   found_q;
  logic                   res_valid_q;
  res_t                   res_q;

  logic                   slot_free;
  logic                   do_load;
  logic                   do_wb;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_wa;
  logic [SIZE_BITS-1:0]   mem_wd;
  logic [SIZE_BITS-1:0]   room;
  logic [SIZE_BITS-1:0]   new_room;
  logic                   fits;
  logic                   take;

  assign cmd_pop_o   = (state_q == ST_IDLE) && cmd_valid_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign slot_free = !res_valid_q || res_pop_i;
  assign do_load   = cmd_pop_o && !cmd_i.is_alloc;
  assign do_wb     = (state_q == ST_WB) && slot_free;
  assign new_room  = best_q - size_q;

  assign mem_we = do_load || (do_wb && found_q);
  assign mem_wa = do_load ? IDX_W'(cmd_i.blk) : pick_q;
  assign mem_wd = do_load ? SIZE_BITS'(cmd_i.size) : new_room;

  // A block never written since reset reads as empty.
  assign room = rd_hit_q ? rd_data_q : '0;
  assign fits = (room >= size_q);

  always_comb begin
    unique case (fit_policy_i)
      FIT_BEST:  take = fits && (!found_q || (room < best_q));
      FIT_WORST: take = fits && (!found_q || (room > best_q));
      default:   take = fits && !found_q;
    endcase
    take = take && cmp_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cap_mem[mem_wa] <= mem_wd;
    end
    rd_data_q <= cap_mem[rd_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vld_q       <= '0;
      rd_idx_q    <= '0;
      rd_hit_q    <= 1'b0;
      cmp_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      size_q      <= '0;
      best_q      <= '0;
      pick_q      <= '0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      rd_hit_q  <= vld_q[rd_idx_q];
      cmp_idx_q <= rd_idx_q;
      cmp_vld_q <= (state_q == ST_SCAN);

      if (mem_we) begin
        vld_q[mem_wa] <= 1'b1;
      end

      if (take) begin
        found_q <= 1'b1;
        best_q  <= room;
        pick_q  <= cmp_idx_q;
      end

      if (res_pop_i && res_valid_q) begin
        res_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o && cmd_i.is_alloc) begin
            size_q   <= SIZE_BITS'(cmd_i.size);
            found_q  <= 1'b0;
            rd_idx_q <= '0;
            state_q  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_idx_q == IDX_W'(NUM_BLOCKS - 1)) begin
            state_q <= ST_DRAIN;
          end else begin
            rd_idx_q <= rd_idx_q + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          // The last block's compare lands in this cycle.
          state_q <= ST_WB;
        end
        ST_WB: begin
          if (slot_free) begin
            res_valid_q <= 1'b1;
            if (found_q) begin
              res_q.granted      <= 1'b1;
              res_q.chosen_block <= BLK_W'(pick_q);
              res_q.room_left    <= SIZE_W'(new_room);
            end else begin
              res_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### verif/tb.sv
// Self-checking testbench for fit_policy_block_allocator_top: load and allocate requests
// go through a queue-style driver, and results are checked against a built-in allocator.
// Depends on fpba_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;
  import fpba_pkg::*;

  localparam int NUM_BLK = 16;
  localparam int DRAIN_CYCLES = 80;
  localparam int LONG_STALL = 300;
  localparam logic [POLICY_W-1:0] FIT_SPARE = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [POLICY_W-1:0] cfg_data_i = '0;
  logic                push_i = 1'b0;
  logic                full_o;
  logic                mode_i = MODE_LOAD;
  logic [BLK_W-1:0]    block_index_i = '0;
  logic [SIZE_W-1:0]   size_value_i = '0;
  logic                empty_o;
  logic                pop_i = 1'b0;
  logic                granted_o;
  logic [BLK_W-1:0]    chosen_block_o;
  logic [SIZE_W-1:0]   room_left_o;

  fit_policy_block_allocator_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .push_i        (push_i),
    .full_o        (full_o),
    .mode_i        (mode_i),
    .block_index_i (block_index_i),
    .size_value_i  (size_value_i),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .granted_o     (granted_o),
    .chosen_block_o(chosen_block_o),
    .room_left_o   (room_left_o)
  );

  // Allocator state as the block should hold it.
  logic [SIZE_W-1:0]   room_tbl [NUM_BLK];
  logic [POLICY_W-1:0] fit_sel = FIT_FIRST;

  cmd_t pending_q [$];
  res_t grant_q [$];

  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_reqs = 0;
  int stall_done = 0;
  int stall_left = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // Update the capacity table for one accepted request and queue the result of an allocate request.
  function automatic void apply_request(input cmd_t c);
    res_t r;
    bit   found;
    int   pick;
    r = '0;
    found = 1'b0;
    pick = 0;
    if (c.is_alloc == MODE_LOAD) begin
      room_tbl[c.blk] = c.size;
      return;
    end
    for (int k = 0; k < NUM_BLK; k++) begin
      if (room_tbl[k[BLK_W-1:0]] < c.size) continue;
      if (!found) begin
        found = 1'b1;
        pick = k;
        // Only best and worst fit look past the first block that fits.
        if (fit_sel != FIT_BEST && fit_sel != FIT_WORST) break;
      end else if (fit_sel == FIT_BEST &&
                   room_tbl[k[BLK_W-1:0]] < room_tbl[pick[BLK_W-1:0]]) begin
        pick = k;
      end else if (fit_sel == FIT_WORST &&
                   room_tbl[k[BLK_W-1:0]] > room_tbl[pick[BLK_W-1:0]]) begin
        pick = k;
      end
    end
    if (found) begin
      room_tbl[pick[BLK_W-1:0]] = room_tbl[pick[BLK_W-1:0]] - c.size;
      r.granted = 1'b1;
      r.chosen_block = pick[BLK_W-1:0];
      r.room_left = room_tbl[pick[BLK_W-1:0]];
    end
    grant_q.push_back(r);
  endfunction

  // Random request, biased toward small sizes and repeated capacities so that
  // grants are common and best and worst fit see ties.
  function automatic cmd_t make_request();
    cmd_t c;
    int   pick;
    c.is_alloc = ($urandom_range(99) < 60) ? MODE_ALLOC : MODE_LOAD;
    c.blk = BLK_W'($urandom_range(NUM_BLK - 1));
    pick = $urandom_range(9);
    if (c.is_alloc == MODE_LOAD) begin
      if (pick == 0) c.size = '0;
      else if (pick == 1) c.size = '1;
      else if (pick <= 5) c.size = SIZE_W'($urandom_range(255));
      else if (pick <= 7) c.size = SIZE_W'(100 * $urandom_range(1, 4));
      else c.size = SIZE_W'($urandom);
    end else begin
      if (pick == 0) c.size = '0;
      else if (pick == 1) c.size = '1;
      else if (pick == 2) c.size = room_tbl[BLK_W'($urandom_range(NUM_BLK - 1))];
      else if (pick <= 6) c.size = SIZE_W'($urandom_range(63));
      else if (pick == 7) c.size = SIZE_W'($urandom_range(300));
      else c.size = SIZE_W'($urandom);
    end
    return c;
  endfunction

  task automatic queue_req(input logic mode, input int blk, input int size);
    cmd_t c;
    c.is_alloc = mode;
    c.blk = blk[BLK_W-1:0];
    c.size = size[SIZE_W-1:0];
    pending_q.push_back(c);
  endtask

  task automatic fill_random(input int n);
    repeat (n) pending_q.push_back(make_request());
  endtask

  // Wait until every request is taken and answered, then let the back end settle
  // on any trailing load requests.
  task automatic drain();
    while (pending_q.size() != 0 || grant_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_policy(input logic [POLICY_W-1:0] p);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= p;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    fit_sel = p;
  endtask

  // Request driver.
  always @(posedge clk_i) begin
    logic offer;
    if (rst_ni) begin
      if (push_i && !full_o) apply_request(pending_q.pop_front());
      if (push_i && full_o) offer = 1'b1;
      else offer = (pending_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
      push_i <= offer;
      if (offer) begin
        mode_i <= pending_q[0].is_alloc;
        block_index_i <= pending_q[0].blk;
        size_value_i <= pending_q[0].size;
      end
    end
  end

  // Result monitor and pop control.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (pop_i && !empty_o) begin
        if (grant_q.size() == 0) begin
          $error("result popped with no request outstanding");
          fail_count++;
        end else begin
          want = grant_q.pop_front();
          if (granted_o !== want.granted) begin
            $error("granted: expected %0d, actual %0d", want.granted, granted_o);
            fail_count++;
          end
          if (chosen_block_o !== want.chosen_block) begin
            $error("chosen_block: expected %0d, actual %0d", want.chosen_block,
                   chosen_block_o);
            fail_count++;
          end
          if (room_left_o !== want.room_left) begin
            $error("room_left: expected %0d, actual %0d", want.room_left, room_left_o);
            fail_count++;
          end
        end
      end
      if (stall_done != stall_reqs) begin
        stall_left <= LONG_STALL;
        stall_done <= stall_reqs;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end
      pop_i <= (stall_done == stall_reqs) && (stall_left == 0) &&
               ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    for (int k = 0; k < NUM_BLK; k++) room_tbl[k[BLK_W-1:0]] = '0;
    send_idle_pct = 33;
    recv_idle_pct = 82;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests under the reset policy (first fit). On the empty table a
    // zero request still fits block 0, anything larger gets no grant.
    queue_req(MODE_ALLOC, 0, 0);
    queue_req(MODE_ALLOC, 9, 1);
    queue_req(MODE_ALLOC, 15, 16'hFFFF);
    queue_req(MODE_LOAD, 0, 16'hFFFF);
    queue_req(MODE_LOAD, 15, 16'hFFFF);
    queue_req(MODE_LOAD, 7, 100);
    queue_req(MODE_ALLOC, 0, 16'hFFFF);
    queue_req(MODE_ALLOC, 0, 100);
    queue_req(MODE_ALLOC, 0, 16'h8000);
    queue_req(MODE_ALLOC, 0, 16'h8000);
    queue_req(MODE_LOAD, 3, 16'h5555);
    queue_req(MODE_LOAD, 12, 16'hAAAA);
    queue_req(MODE_ALLOC, 5, 16'h5555);
    queue_req(MODE_ALLOC, 10, 0);
    queue_req(MODE_ALLOC, 6, 16'h2AAA);
    queue_req(MODE_LOAD, 8, 1);
    queue_req(MODE_LOAD, 1, 1);
    queue_req(MODE_ALLOC, 0, 1);
    queue_req(MODE_LOAD, 15, 0);
    queue_req(MODE_ALLOC, 0, 16'h7FFF);
    queue_req(MODE_ALLOC, 0, 16'h8001);
    drain();

    write_policy(FIT_BEST);
    fill_random(130);
    drain();

    send_idle_pct = 82;
    recv_idle_pct = 33;
    write_policy(FIT_WORST);
    fill_random(130);
    drain();

    // The spare policy code must behave as first fit.
    write_policy(FIT_SPARE);
    fill_random(100);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_policy(FIT_FIRST);
    fill_random(120);
    // Hold off popping while requests keep coming so the input side backs up.
    stall_reqs++;
    drain();

    write_policy(FIT_BEST);
    fill_random(110);
    drain();

    write_policy(FIT_WORST);
    fill_random(110);
    drain();

    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
